/* sv/mwo_pkg.sv */
// ----------------------------------------------------------------------------
// Oscillator mixer package
// Shared types, register indexes, wave codes, fixed-point constants and the
// quarter-wave sine table generator.
// ----------------------------------------------------------------------------
package mwo_pkg;

   // Configuration register indexes.
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PHASE_STEP    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WAVE_SELECT   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FOLD_ABSOLUTE = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VOLUME        = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIX_PERCENT   = 3'd4;

   // Wave shape codes. Codes six and seven give a silent wave.
   typedef enum logic [2:0] {
      WAVE_PARABOLA = 3'd0,
      WAVE_SINE     = 3'd1,
      WAVE_SQUARE   = 3'd2,
      WAVE_PULSE    = 3'd3,
      WAVE_TRIANGLE = 3'd4,
      WAVE_SAW      = 3'd5
   } wave_sel_type;

   // Configuration registers as seen by the front and back ends.
   typedef struct packed {
      logic [31:0] phase_step;
      logic [2:0]  wave_select;
      logic        fold_absolute;
      logic [15:0] volume;
      logic [6:0]  mix_percent;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      phase_step:    32'd0,
      wave_select:   3'd1,
      fold_absolute: 1'b0,
      volume:        16'd0,
      mix_percent:   7'd0
   };

   // Wave value in sign and magnitude form; Q2.14, largest magnitude is the
   // parabola peak of 17967.
   localparam int WAVE_MAG_BITS = 15;

   typedef struct packed {
      logic                     neg;
      logic [WAVE_MAG_BITS-1:0] mag;
   } wave_type;

   localparam logic [14:0] Q14_ONE = 15'd16384;

   // Parabola: round(17967 * d^2 / 2^28).
   localparam logic [14:0] PARA_PEAK  = 15'd17967;
   localparam logic [43:0] PARA_ROUND = 44'd134217728;

   // Scaling: wave * volume * mix / (100 * 2^15), rounded half away from
   // zero. Half the divisor is added first, the low 15 bits are dropped and
   // the remaining quotient by 100 is taken as a product with ceil(2^30/100),
   // which is exact for every reachable operand below 2^23.
   localparam logic [37:0] OSC_ROUND   = 38'd1638400;
   localparam logic [23:0] RECIP_100   = 24'd10737419;

   // Quarter-wave sine table, evaluated at elaboration.
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [7:0] TAYLOR_DIV [1:7] = '{8'd6, 8'd20, 8'd42, 8'd72,
                                               8'd110, 8'd156, 8'd210};

   // Entry k of a table with 2^addr_bits steps per quarter turn:
   // round(16384 * sin(pi/2 * k / 2^addr_bits)) from a Q30 Taylor series.
   function automatic logic [14:0] sine_entry(input int unsigned k,
                                              input int unsigned addr_bits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] pos;
      logic [63:0] neg;
      logic [63:0] diff;
      logic [63:0] rounded;
      x    = (HALF_PI_Q30 * 64'(k)) >> addr_bits;
      x2   = (x * x) >> 30;
      term = x;
      pos  = x;
      neg  = 64'd0;
      for (int n = 1; n <= 7; n++) begin
         term = ((term * x2) >> 30) / 64'(TAYLOR_DIV[n]);
         if (n % 2 == 1) begin
            neg = neg + term;
         end else begin
            pos = pos + term;
         end
      end
      diff    = (pos > neg) ? pos - neg : 64'd0;
      rounded = diff + 64'd32768;
      return rounded[30:16];
   endfunction

endpackage

/* sv/mwo_sine_rom.sv */
// ----------------------------------------------------------------------------
// Quarter-wave sine table
// Constant table of 2^ADDR_BITS + 1 Q2.14 entries with a registered read.
// ----------------------------------------------------------------------------
module mwo_sine_rom import mwo_pkg::*; #(
   parameter int ADDR_BITS = 10
) (
   input  logic               clock,
   input  logic               rd_en,
   input  logic [ADDR_BITS:0] rd_addr,
   output logic [14:0]        rd_data
);

   localparam int DEPTH = (1 << ADDR_BITS) + 1;

   logic [14:0] rom [DEPTH];
   logic [14:0] rd_data_ff;

   // Table contents come from the package generator.
   for (genvar k = 0; k < DEPTH; k++) begin : g_rom
      assign rom[k] = sine_entry(k, ADDR_BITS);
   end

   // Registered read, held while no read is requested.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= rom[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/mwo_fifo.sv */
// ----------------------------------------------------------------------------
// Frame queue
// Short flip-flop queue between the wave front end and the scaling back end.
// ----------------------------------------------------------------------------
module mwo_fifo #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   localparam logic [PTR_BITS-1:0]   LAST_PTR  = PTR_BITS'(DEPTH - 1);
   localparam logic [COUNT_BITS-1:0] FULL_CNT  = COUNT_BITS'(DEPTH);

   logic [WIDTH-1:0]      mem_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff;
   logic [PTR_BITS-1:0]   wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff;
   logic [PTR_BITS-1:0]   rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;

   // Pointer wrap and occupancy.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset; occupancy decides what is valid.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

`ifndef ASSERT_OFF
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("frame queue written while full");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("frame queue read while empty");
`endif

endmodule

/* sv/mwo_front.sv */
// ----------------------------------------------------------------------------
// Oscillator front end
// Accepts frames, runs the phase accumulator and shapes the wave value that
// goes with each frame into the queue.
// ----------------------------------------------------------------------------
module mwo_front import mwo_pkg::*; #(
   parameter int PHASE_BITS           = 32,
   parameter int SINE_TABLE_ADDR_BITS = 10,
   parameter int SAMPLE_BITS          = 16,
   localparam int TDATA_BITS          = ((2 * SAMPLE_BITS + 7) / 8) * 8,
   localparam int ITEM_BITS           = 2 * SAMPLE_BITS + 1 + $bits(wave_type)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [TDATA_BITS-1:0] req_tdata,   // left_in, right_in, zero fill
   input  logic                  req_tlast,   // block_end
   output logic                  push,
   output logic [ITEM_BITS-1:0]  push_data,
   input  logic                  full
);

   localparam int AB = SINE_TABLE_ADDR_BITS;

   localparam logic [AB:0]           TBL_N   = {1'b1, {AB{1'b0}}};
   localparam logic [PHASE_BITS-1:0] QUARTER = {2'b01, {(PHASE_BITS - 2){1'b0}}};

   typedef enum logic {
      FR_IDLE,
      FR_SHAPE
   } state_type;

   state_type               state_ff;
   state_type               state_in;
   logic [PHASE_BITS-1:0]   phase_ff;
   logic [PHASE_BITS-1:0]   phase_in;
   logic [PHASE_BITS-1:0]   step;
   logic                    accept;

   // Phase decode of the current phase.
   logic [15:0]             p16;
   logic [14:0]             mir;
   logic [29:0]             mir_sq;
   logic [AB-1:0]           tbl_a;
   logic [AB:0]             tbl_idx;

   // Captured per-frame values.
   logic [SAMPLE_BITS-1:0]  left_ff;
   logic [SAMPLE_BITS-1:0]  right_ff;
   logic                    last_ff;
   logic [1:0]              quad_ff;
   logic [14:0]             mir_ff;
   logic [28:0]             dsq_ff;
   logic                    pulse_ff;
   logic [14:0]             top15_ff;

   // Shaping.
   logic [14:0]             sine_mag;
   logic [43:0]             para_full;
   logic [14:0]             para_mag;
   logic [14:0]             shape_mag;
   logic                    shape_neg;
   wave_type                wave;

   // Step scaled to the accumulator width.
   if (PHASE_BITS >= 32) begin : g_step_wide
      assign step = PHASE_BITS'(cfg.phase_step) << (PHASE_BITS - 32);
   end else begin : g_step_narrow
      assign step = PHASE_BITS'(cfg.phase_step >> (32 - PHASE_BITS));
   end

   assign req_tready = (state_ff == FR_IDLE);
   assign accept     = req_tvalid && req_tready;

   // Quarter, position in the quarter and its mirror.
   assign p16     = phase_ff[PHASE_BITS-1 -: 16];
   assign mir     = p16[14] ? Q14_ONE - {1'b0, p16[13:0]} : {1'b0, p16[13:0]};
   assign mir_sq  = 30'(mir) * 30'(mir);
   assign tbl_a   = phase_ff[PHASE_BITS-3 -: AB];
   assign tbl_idx = p16[14] ? TBL_N - {1'b0, tbl_a} : {1'b0, tbl_a};

   mwo_sine_rom #(
      .ADDR_BITS (AB)
   ) u_sine_rom (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (tbl_idx),
      .rd_data (sine_mag)
   );

   // Parabola from the registered square of the mirrored position.
   assign para_full = 44'(PARA_PEAK) * 44'(dsq_ff) + PARA_ROUND;
   assign para_mag  = para_full[42:28];

   // Wave in sign and magnitude form.
   always_comb begin
      shape_mag = '0;
      shape_neg = 1'b0;
      case (cfg.wave_select)
         WAVE_PARABOLA: begin
            shape_mag = para_mag;
            shape_neg = quad_ff[1];
         end
         WAVE_SINE: begin
            shape_mag = sine_mag;
            shape_neg = quad_ff[1];
         end
         WAVE_SQUARE: begin
            shape_mag = (sine_mag != '0) ? Q14_ONE : '0;
            shape_neg = quad_ff[1];
         end
         WAVE_PULSE: begin
            shape_mag = pulse_ff ? Q14_ONE : '0;
         end
         WAVE_TRIANGLE: begin
            shape_mag = mir_ff;
            shape_neg = quad_ff[1];
         end
         WAVE_SAW: begin
            if (top15_ff > Q14_ONE) begin
               shape_mag = top15_ff - Q14_ONE;
               shape_neg = 1'b1;
            end else begin
               shape_mag = Q14_ONE - top15_ff;
            end
         end
         default: begin
            shape_mag = '0;
         end
      endcase
      wave.mag = shape_mag;
      wave.neg = shape_neg && !cfg.fold_absolute && (shape_mag != '0);
   end

   assign push      = (state_ff == FR_SHAPE) && !full;
   assign push_data = {last_ff, wave, right_ff, left_ff};

   // Next state and phase.
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      case (state_ff)
         FR_IDLE: begin
            if (accept) begin
               phase_in = phase_ff + step;
               state_in = FR_SHAPE;
            end
         end
         FR_SHAPE: begin
            if (!full) begin
               state_in = FR_IDLE;
            end
         end
         default: begin
            state_in = FR_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
         phase_ff <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         if (accept) begin
            left_ff  <= req_tdata[SAMPLE_BITS-1:0];
            right_ff <= req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
            last_ff  <= req_tlast;
            quad_ff  <= p16[15:14];
            mir_ff   <= mir;
            dsq_ff   <= mir_sq[28:0];
            pulse_ff <= (phase_ff <= QUARTER);
            top15_ff <= phase_ff[PHASE_BITS-1 -: 15];
         end
      end
   end

`ifndef ASSERT_OFF
   a_phase_moves_on_accept: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(phase_ff))
      else $error("phase changed without a frame transfer");
`endif

endmodule

/* sv/mwo_back.sv */
// ----------------------------------------------------------------------------
// Oscillator back end
// Scales the queued wave by volume and mix, adds it to both channels with
// saturation and holds the result in the output register.
// ----------------------------------------------------------------------------
module mwo_back import mwo_pkg::*; #(
   parameter int SAMPLE_BITS = 16,
   localparam int TDATA_BITS = ((2 * SAMPLE_BITS + 7) / 8) * 8,
   localparam int ITEM_BITS  = 2 * SAMPLE_BITS + 1 + $bits(wave_type)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic [ITEM_BITS-1:0]  pop_data,
   input  logic                  empty,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [TDATA_BITS-1:0] rsp_tdata,   // left_out, right_out, zero fill
   output logic                  rsp_tlast    // block_end_out
);

   localparam int SB   = SAMPLE_BITS;
   localparam int SUMW = ((SB > 17) ? SB : 17) + 1;

   localparam logic signed [SUMW-1:0] SAT_HI = SUMW'((1 << (SB - 1)) - 1);
   localparam logic signed [SUMW-1:0] SAT_LO = SUMW'(-(1 << (SB - 1)));

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_MIX,
      BK_RECIP,
      BK_DONE
   } state_type;

   state_type              state_ff;
   state_type              state_in;

   wave_type               head_wave;
   logic signed [SB-1:0]   left_ff;
   logic signed [SB-1:0]   right_ff;
   logic                   last_ff;
   logic                   neg_ff;
   logic [30:0]            wv_ff;
   logic [37:0]            p_ff;
   logic [46:0]            qm_ff;

   logic signed [16:0]     osc_pos;
   logic signed [16:0]     osc;
   logic signed [SUMW-1:0] sum_left;
   logic signed [SUMW-1:0] sum_right;
   logic                   load_out;

   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [SB-1:0]          rsp_left_ff;
   logic [SB-1:0]          rsp_right_ff;
   logic                   rsp_last_ff;

   function automatic logic [SB-1:0] saturate(input logic signed [SUMW-1:0] v);
      logic signed [SUMW-1:0] c;
      c = v;
      if (v > SAT_HI) begin
         c = SAT_HI;
      end else if (v < SAT_LO) begin
         c = SAT_LO;
      end
      return c[SB-1:0];
   endfunction

   assign head_wave = pop_data[2*SB +: $bits(wave_type)];
   assign pop       = (state_ff == BK_IDLE) && !empty;

   // Rounded oscillator value with its sign restored.
   assign osc_pos   = $signed({1'b0, qm_ff[45:30]});
   assign osc       = neg_ff ? -osc_pos : osc_pos;
   assign sum_left  = SUMW'(left_ff) + SUMW'(osc);
   assign sum_right = SUMW'(right_ff) + SUMW'(osc);

   // The output register takes a result when empty or being emptied.
   assign load_out  = (state_ff == BK_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!empty) begin
               state_in = BK_MIX;
            end
         end
         BK_MIX: begin
            state_in = BK_RECIP;
         end
         BK_RECIP: begin
            state_in = BK_DONE;
         end
         BK_DONE: begin
            if (load_out) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         // Wave magnitude times volume as the frame leaves the queue.
         if (pop) begin
            left_ff  <= pop_data[SB-1:0];
            right_ff <= pop_data[2*SB-1:SB];
            last_ff  <= pop_data[ITEM_BITS-1];
            neg_ff   <= head_wave.neg;
            wv_ff    <= 31'(head_wave.mag) * 31'(cfg.volume);
         end
         // Times mix, plus half the divisor for rounding.
         if (state_ff == BK_MIX) begin
            p_ff <= 38'(wv_ff) * 38'(cfg.mix_percent) + OSC_ROUND;
         end
         // Drop 2^15, then divide by 100 through the reciprocal.
         if (state_ff == BK_RECIP) begin
            qm_ff <= 47'(p_ff[37:15]) * 47'(RECIP_100);
         end
         if (load_out) begin
            rsp_left_ff  <= saturate(sum_left);
            rsp_right_ff <= saturate(sum_right);
            rsp_last_ff  <= last_ff;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_BITS'({rsp_right_ff, rsp_left_ff});
   assign rsp_tlast  = rsp_last_ff;

`ifndef ASSERT_OFF
   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == BK_DONE))
      else $error("result raised outside the final scaling step");
`endif

endmodule

/* sv/multi_waveform_oscillator_mixer_core.sv */
// ----------------------------------------------------------------------------
// Multi-waveform oscillator mixer
// Phase-accumulator oscillator with six wave shapes, scaled by volume and
// mix percent and added to both channels of a stereo stream.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one stereo frame per transfer (left in the low half of
//   tdata, right above it, block end on tlast). rsp_* returns one frame per
//   input frame in the same order, with the oscillator added and each
//   channel saturated; tlast is copied through.
//   csr_* writes a register: 0 phase step, 1 wave select,
//   2 fold to absolute value, 3 volume, 4 mix percent. Write only while
//   no frame is in flight.
//   The front end accepts a frame, then reads the sine table and shapes
//   the wave before it takes the next one; the back end's four-step
//   sequence (volume multiply, mix multiply, reciprocal divide by 100, sum
//   and saturate) sets the sustained rate, since it takes the next frame
//   from the queue only once the last one is done.
//   A two-entry queue separates the ends. When the receiver stalls, the
//   finished frame waits in the output register while the back end works on
//   the next one; the queue then fills and req_tready drops.
//   Synchronous reset clears the phase, the queue and the output register,
//   and loads the register reset values (wave select is sine).
// ----------------------------------------------------------------------------
module multi_waveform_oscillator_mixer_core import mwo_pkg::*; #(
   parameter int PHASE_BITS           = 32,
   parameter int SINE_TABLE_ADDR_BITS = 10,
   parameter int SAMPLE_BITS          = 16,
   localparam int TDATA_BITS          = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [TDATA_BITS-1:0]     req_tdata,   // left_in, right_in, zero fill
   input  logic                      req_tlast,   // block_end
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [TDATA_BITS-1:0]     rsp_tdata,   // left_out, right_out, zero fill
   output logic                      rsp_tlast,   // block_end_out
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int ITEM_BITS   = 2 * SAMPLE_BITS + 1 + $bits(wave_type);
   localparam int QUEUE_DEPTH = 2;

   cfg_type              cfg_ff;
   logic                 push;
   logic [ITEM_BITS-1:0] push_data;
   logic                 full;
   logic                 pop;
   logic [ITEM_BITS-1:0] pop_data;
   logic                 empty;

   // Configuration registers; writes to unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PHASE_STEP:    cfg_ff.phase_step    <= csr_wdata;
            CSR_WAVE_SELECT:   cfg_ff.wave_select   <= csr_wdata[2:0];
            CSR_FOLD_ABSOLUTE: cfg_ff.fold_absolute <= csr_wdata[0];
            CSR_VOLUME:        cfg_ff.volume        <= csr_wdata[15:0];
            CSR_MIX_PERCENT:   cfg_ff.mix_percent   <= csr_wdata[6:0];
            default: begin
            end
         endcase
      end
   end

   mwo_front #(
      .PHASE_BITS           (PHASE_BITS),
      .SINE_TABLE_ADDR_BITS (SINE_TABLE_ADDR_BITS),
      .SAMPLE_BITS          (SAMPLE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push       (push),
      .push_data  (push_data),
      .full       (full)
   );

   mwo_fifo #(
      .WIDTH (ITEM_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   mwo_back #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pop_data   (pop_data),
      .empty      (empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* tb/sv/multi_waveform_oscillator_mixer_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Oscillator mixer testbench
// Drives stereo frames through the mixer core and checks every returned
// frame against a typed result or a cycle-free model of the oscillator:
// phase accumulator, six wave shapes, folding, volume and mix scaling and
// channel saturation. A directed table covers the extremes and every wave code;
// random phases with fresh register settings and varied back-pressure follow.
// ----------------------------------------------------------------------------
module multi_waveform_oscillator_mixer_core_tb;
   import mwo_pkg::*;

   // Wave codes without a shape and register indexes that decode to nothing.
   localparam logic [2:0] WAVE_SILENT_LO = 3'd6;
   localparam logic [2:0] WAVE_SILENT_HI = 3'd7;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_5 = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_7 = 3'd7;

   // Fixed-point constants of the oscillator.
   localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
   localparam int  UNITY_Q14     = 16384;
   localparam int  LUT_STEPS     = 1024;
   localparam longint PARA_PEAK_Q14 = 17967;
   localparam longint OSC_DIV    = 100 * 32768;

   localparam int PHASES        = 14;
   localparam int FRAMES_PER_PHASE = 50;

   typedef struct packed {
      logic signed [15:0] left;
      logic signed [15:0] right;
      logic               last;
   } audio_frame_type;

   typedef enum logic [1:0] {ROW_CSR, ROW_FRAME, ROW_TYPED} row_kind_type;

   // Register write, frame checked by the model, or frame with a typed result.
   typedef struct packed {
      row_kind_type              kind;
      logic [CSR_INDEX_BITS-1:0] idx;
      logic [31:0]               value;
      logic [15:0]               left;
      logic [15:0]               right;
      logic                      last;
      logic [15:0]               want_left;
      logic [15:0]               want_right;
   } stim_row_type;

   localparam int DIR_ROWS = 43;
   localparam stim_row_type DIR_TBL [DIR_ROWS] = '{
      // After reset the volume and mix are zero, so frames pass unchanged.
      '{ROW_TYPED, CSR_PHASE_STEP, 32'h0, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
      '{ROW_TYPED, CSR_PHASE_STEP, 32'h0, 16'h7FFF, 16'h8000, 1'b1, 16'h7FFF, 16'h8000},
      '{ROW_TYPED, CSR_PHASE_STEP, 32'h0, 16'h8000, 16'h7FFF, 1'b0, 16'h8000, 16'h7FFF},
      '{ROW_TYPED, CSR_PHASE_STEP, 32'h0, 16'h5555, 16'hAAAA, 1'b1, 16'h5555, 16'hAAAA},
      // Sine at the four quarter points, full volume and mix.
      '{ROW_CSR, CSR_PHASE_STEP, 32'h4000_0000, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
      '{ROW_CSR, CSR_VOLUME,     32'h0000_FFFF, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
      '{ROW_CSR, CSR_MIX_PERCENT, 32'd100,      16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
      '{ROW_FRAME, CSR_PHASE_STEP, 32'h0, 16'h0000, 16'h0000, 1'b0, 16'h0, 16'h0},
      '{ROW_FRAME, CSR_PHASE_STEP, 32'h0, 16'h8000, 16'h7FFF, 1'b0, 16'h0, 16'h0},
      '{ROW_FRAME, CSR_PHASE_STEP, 32'h0, 16'h0000, 16'hFFFF, 1'b0, 16'h0, 16'h0},
      '{ROW_FRAME, CSR_PHASE_STEP, 32'h0, 16'h7FFF, 16'h8000, 1'b1, 16'h0, 16'h0},
      // Parabola with a half-turn step.
      '{ROW_CSR, CSR_WAVE_SELECT, 32'(WAVE_PARABOLA), 16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
      '{ROW_CSR, CSR_PHASE_STEP,  32'h8000_0000,      16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
      '{ROW_FRAME, CSR_PHASE_STEP, 32'h0, 16'hFFFF, 16'h0001, 1'b0, 16'h0, 16'h0},
      '{ROW_FRAME, CSR_PHASE_STEP, 32'h0, 16'd100,  16'hFF9C, 1'b1, 16'h0, 16'h0},
      // Square.
      '{ROW_CSR, CSR_WAVE_SELECT, 32'(WAVE_SQUARE), 16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
      '{ROW_CSR, CSR_PHASE_STEP,  32'h1234_5678,    16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
      '{ROW_FRAME, CSR_PHASE_STEP, 32'h0, 16'h0000, 16'h0000, 1'b0, 16'h0, 16'h0},
      '{ROW_FRAME, CSR_PHASE_STEP, 32'h0, 16'd1000, 16'hFC18, 1'b0, 16'h0, 16'h0},
      // Quarter pulse at half volume.
      '{ROW_CSR, CSR_WAVE_SELECT, 32'(WAVE_PULSE), 16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
      '{ROW_CSR, CSR_VOLUME,      32'h0000_8000,   16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
      '{ROW_FRAME, CSR_PHASE_STEP, 32'h0, 16'h0000, 16'h0000, 1'b0, 16'h0, 16'h0},
      '{ROW_FRAME, CSR_PHASE_STEP, 32'h0, 16'h0000, 16'h0000, 1'b1, 16'h0, 16'h0},
      // Triangle folded to its absolute value.
      '{ROW_CSR, CSR_WAVE_SELECT,   32'(WAVE_TRIANGLE), 16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
      '{ROW_CSR, CSR_FOLD_ABSOLUTE, 32'd1,              16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
      '{ROW_FRAME, CSR_PHASE_STEP, 32'h0, 16'h8000, 16'h8000, 1'b0, 16'h0, 16'h0},
      '{ROW_FRAME, CSR_PHASE_STEP, 32'h0, 16'd12345, 16'hCFC7, 1'b0, 16'h0, 16'h0},
      // Saw, unfolded.
      '{ROW_CSR, CSR_WAVE_SELECT,   32'(WAVE_SAW), 16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
      '{ROW_CSR, CSR_FOLD_ABSOLUTE, 32'd0,         16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
      '{ROW_FRAME, CSR_PHASE_STEP, 32'h0, 16'h1234, 16'hEDCC, 1'b0, 16'h0, 16'h0},
      '{ROW_FRAME, CSR_PHASE_STEP, 32'h0, 16'h7FFF, 16'h8000, 1'b1, 16'h0, 16'h0},
      // Codes without a shape give a silent wave: frames pass unchanged.
      '{ROW_CSR, CSR_WAVE_SELECT, 32'(WAVE_SILENT_LO), 16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
      '{ROW_TYPED, CSR_PHASE_STEP, 32'h0, 16'h8000, 16'h7FFF, 1'b1, 16'h8000, 16'h7FFF},
      '{ROW_CSR, CSR_WAVE_SELECT, 32'(WAVE_SILENT_HI), 16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
      // Writes to indexes past the last register must not land anywhere.
      '{ROW_CSR, CSR_SPARE_5, 32'd1,         16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
      '{ROW_CSR, CSR_SPARE_6, 32'hFFFF_FFFF, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
      '{ROW_CSR, CSR_SPARE_7, 32'hFFFF_FFFF, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
      '{ROW_TYPED, CSR_PHASE_STEP, 32'h0, 16'h7FFF, 16'h8000, 1'b0, 16'h7FFF, 16'h8000},
      // Mix above one hundred percent with the largest step: the sums of the second frame saturate.
      '{ROW_CSR, CSR_WAVE_SELECT, 32'(WAVE_SINE), 16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
      '{ROW_CSR, CSR_MIX_PERCENT, 32'd127,        16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
      '{ROW_CSR, CSR_PHASE_STEP,  32'hFFFF_FFFF,  16'h0, 16'h0, 1'b0, 16'h0, 16'h0},
      '{ROW_FRAME, CSR_PHASE_STEP, 32'h0, 16'h7FFF, 16'h7FFF, 1'b0, 16'h0, 16'h0},
      '{ROW_FRAME, CSR_PHASE_STEP, 32'h0, 16'h8000, 16'h8000, 1'b1, 16'h0, 16'h0}
   };

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [31:0]               req_tdata = '0;   // left_in, right_in
   logic                      req_tlast = 1'b0; // block_end
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [31:0]               rsp_tdata;        // left_out, right_out
   logic                      rsp_tlast;        // block_end_out
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // Model state and register copies.
   logic [31:0] phase_acc;
   logic [31:0] step_cfg;
   logic [2:0]  wave_cfg;
   logic        fold_cfg;
   logic [15:0] vol_cfg;
   logic [6:0]  mix_cfg;
   int          sine_lut [0:LUT_STEPS];

   audio_frame_type mixed_q [$];
   int              errors    = 0;
   int              gap_pct   = 0;
   int              stall_pct = 0;
   int              hold_left = 0;

   multi_waveform_oscillator_mixer_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Hard stop in case the block hangs.
   initial begin
      #3_000_000;
      $display("FAILURE");
      $finish;
   end

   // Quarter-wave sine entry in Q14 from a Q30 Taylor series.
   function automatic int quarter_sine(input int k);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned pos;
      longint unsigned neg;
      longint unsigned diff;
      x    = (QUARTER_TURN_Q30 * longint'(k)) / LUT_STEPS;
      x2   = (x * x) >> 30;
      term = x;
      pos  = x;
      neg  = 0;
      for (int n = 1; n <= 7; n++) begin
         term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            neg += term;
         end else begin
            pos += term;
         end
      end
      diff = (pos > neg) ? pos - neg : 0;
      return int'((diff + 32768) >> 16);
   endfunction

   // Wave value in Q14 at the current phase, after optional folding.
   function automatic int oscillator_sample();
      logic [1:0]  quad;
      logic [13:0] fpos;
      logic [9:0]  lut_addr;
      int          mir;
      int          v;
      longint      d2;
      quad     = phase_acc[31:30];
      fpos     = phase_acc[29:16];
      lut_addr = phase_acc[29:20];
      mir      = quad[0] ? UNITY_Q14 - int'(fpos) : int'(fpos);
      case (wave_cfg)
         WAVE_PARABOLA: begin
            d2 = longint'(mir) * longint'(mir);
            v  = int'((PARA_PEAK_Q14 * d2 + 64'd134217728) >>> 28);
            if (quad[1]) v = -v;
         end
         WAVE_SINE, WAVE_SQUARE: begin
            v = sine_lut[quad[0] ? LUT_STEPS - int'(lut_addr) : int'(lut_addr)];
            if (quad[1]) v = -v;
            if (wave_cfg == WAVE_SQUARE) begin
               v = (v > 0) ? UNITY_Q14 : ((v < 0) ? -UNITY_Q14 : 0);
            end
         end
         WAVE_PULSE:    v = (phase_acc <= 32'h4000_0000) ? UNITY_Q14 : 0;
         WAVE_TRIANGLE: v = quad[1] ? -mir : mir;
         WAVE_SAW:      v = UNITY_Q14 - int'(phase_acc[31:17]);
         default:       v = 0;
      endcase
      if (fold_cfg && v < 0) v = -v;
      return v;
   endfunction

   function automatic logic signed [15:0] clamp16(input longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   // Expected output frame for one input frame; advances the phase.
   function automatic audio_frame_type mix_frame(input audio_frame_type stim);
      audio_frame_type want;
      longint          prod;
      longint          mag;
      longint          osc;
      prod = longint'(oscillator_sample()) * longint'(vol_cfg) * longint'(mix_cfg);
      mag  = (prod < 0) ? -prod : prod;
      osc  = (mag + OSC_DIV / 2) / OSC_DIV;
      if (prod < 0) osc = -osc;
      want.left  = clamp16(longint'(stim.left) + osc);
      want.right = clamp16(longint'(stim.right) + osc);
      want.last  = stim.last;
      phase_acc  = phase_acc + step_cfg;
      return want;
   endfunction

   // One register write; called at a falling edge, returns at a falling edge.
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_PHASE_STEP:    step_cfg = value;
         CSR_WAVE_SELECT:   wave_cfg = value[2:0];
         CSR_FOLD_ABSOLUTE: fold_cfg = value[0];
         CSR_VOLUME:        vol_cfg  = value[15:0];
         CSR_MIX_PERCENT:   mix_cfg  = value[6:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Offer one frame until it is taken, then record what must come back.
   task automatic send_frame(input audio_frame_type stim, input bit use_typed,
                             input audio_frame_type typed_want);
      audio_frame_type predicted;
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {stim.right, stim.left};
      req_tlast  <= stim.last;
      do @(posedge clock); while (!req_tready);
      predicted = mix_frame(stim);
      mixed_q.push_back(use_typed ? typed_want : predicted);
      @(negedge clock);
   endtask

   // Stop sending and let every pending frame come back.
   task automatic drain_pipe();
      req_tvalid <= 1'b0;
      while (mixed_q.size() != 0) @(posedge clock);
      repeat (8) @(negedge clock);
   endtask

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(9))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         default: return 16'($urandom());
      endcase
   endfunction

   // Fresh register settings for a random phase; the first two are extremes.
   task automatic load_settings(input int ph);
      logic [31:0] step;
      logic [15:0] vol;
      logic [6:0]  mix;
      case ($urandom_range(4))
         0:       step = 32'($urandom_range(1 << 20));
         1:       step = 32'h8000_0000;
         2:       step = 32'hFFFF_FFFF;
         default: step = $urandom();
      endcase
      case ($urandom_range(3))
         0:       vol = 16'hFFFF;
         1:       vol = 16'h0000;
         default: vol = 16'($urandom());
      endcase
      mix = ($urandom_range(3) == 0) ? 7'($urandom_range(127, 101))
                                     : 7'($urandom_range(100));
      if (ph == 0) begin
         step = 32'h8000_0000;
         vol  = 16'hFFFF;
         mix  = 7'd127;
      end else if (ph == 1) begin
         step = 32'h0;
         vol  = 16'h0;
         mix  = 7'd0;
      end
      // Upper bits of the narrow registers carry noise that must be dropped.
      write_reg(CSR_PHASE_STEP, step);
      write_reg(CSR_WAVE_SELECT, ($urandom() << 3) | 32'($urandom_range(7)));
      write_reg(CSR_FOLD_ABSOLUTE, ($urandom() << 1) | 32'($urandom_range(1)));
      write_reg(CSR_VOLUME, ($urandom() << 16) | 32'(vol));
      write_reg(CSR_MIX_PERCENT, ($urandom() << 7) | 32'(mix));
      write_reg(3'($urandom_range(7, 5)), $urandom());
   endtask

   // Receiver: random stalls per phase, plus a long hold-off on request.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Compare each output transfer with the oldest pending frame.
   always @(posedge clock) begin
      audio_frame_type want;
      audio_frame_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.left  = rsp_tdata[15:0];
         got.right = rsp_tdata[31:16];
         got.last  = rsp_tlast;
         if (mixed_q.size() == 0) begin
            $error("output transfer with no frame pending");
            errors++;
         end else begin
            want = mixed_q.pop_front();
            if (got.left !== want.left) begin
               $error("left_out: expected %0d, got %0d", want.left, got.left);
               errors++;
            end
            if (got.right !== want.right) begin
               $error("right_out: expected %0d, got %0d", want.right, got.right);
               errors++;
            end
            if (got.last !== want.last) begin
               $error("block_end_out: expected %0d, got %0d", want.last, got.last);
               errors++;
            end
         end
      end
   end

   initial begin
      stim_row_type    row;
      audio_frame_type stim;
      audio_frame_type typed_want;
      for (int k = 0; k <= LUT_STEPS; k++) sine_lut[k] = quarter_sine(k);
      phase_acc = '0;
      step_cfg  = '0;
      wave_cfg  = WAVE_SINE;
      fold_cfg  = 1'b0;
      vol_cfg   = '0;
      mix_cfg   = '0;

      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table.
      for (int i = 0; i < DIR_ROWS; i++) begin
         row = DIR_TBL[i];
         if (row.kind == ROW_CSR) begin
            drain_pipe();
            write_reg(row.idx, row.value);
         end else begin
            stim.left        = row.left;
            stim.right       = row.right;
            stim.last        = row.last;
            typed_want.left  = row.want_left;
            typed_want.right = row.want_right;
            typed_want.last  = row.last;
            send_frame(stim, row.kind == ROW_TYPED, typed_want);
         end
      end

      // Random phases, cycling through the idling patterns.
      for (int ph = 0; ph < PHASES; ph++) begin
         drain_pipe();
         load_settings(ph);
         case (ph % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 45; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 45; end
            default: begin gap_pct = 25; stall_pct = 25; end
         endcase
         // Long hold-off while frames keep coming, so the input backs up.
         if (ph == 2) hold_left = 80;
         for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
            if (ph == 5 && n == FRAMES_PER_PHASE / 2) drain_pipe();
            stim.left  = pick_sample();
            stim.right = pick_sample();
            stim.last  = ($urandom_range(7) == 0);
            send_frame(stim, 1'b0, stim);
         end
      end

      drain_pipe();
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* files.f */
sv/mwo_pkg.sv
sv/mwo_sine_rom.sv
sv/mwo_fifo.sv
sv/mwo_front.sv
sv/mwo_back.sv
sv/multi_waveform_oscillator_mixer_core.sv
tb/sv/multi_waveform_oscillator_mixer_core_tb.sv
